// File: hw/rtl/mbfr_pkg.sv
package mbfr_pkg;

    localparam int DEF_MAX_PAYLOAD_BYTES = 64;
    localparam int DEF_MAX_FIELD_BITS    = 64;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 7;
    localparam int FIELD_W  = 64;
    localparam int SH_W     = 3;
    localparam int ACC_BYTES = FIELD_W / BYTE_W + 1;
    localparam int ACC_W    = ACC_BYTES * BYTE_W;
    localparam int COL_W    = $clog2(ACC_BYTES + 1);
    localparam int S_DATA_W = ((BYTE_W + LEN_W + 7) / 8) * 8;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic clear;
        logic shift;
        logic zero;
    } t_shift_ctl;

    // Keeps the top len bits of a field word and clears the rest.
    function automatic logic [FIELD_W-1:0] keep_mask(input logic [LEN_W-1:0] len);
        logic [FIELD_W-1:0] m;
        for (int j = 0; j < FIELD_W; j++) begin
            m[j] = (FIELD_W - 1 - j) < int'(len);
        end
        return m;
    endfunction

endpackage

// File: hw/rtl/mbfr_ram.sv
module mbfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/mbfr_shifter.sv
module mbfr_shifter (
    input  logic                                 i_clk,
    input  mbfr_pkg::t_shift_ctl                 i_ctl,
    input  logic [mbfr_pkg::BYTE_W-1:0]          i_din,
    input  logic [mbfr_pkg::SH_W-1:0]            i_sh,
    input  logic [mbfr_pkg::LEN_W-1:0]           i_len,
    output logic [mbfr_pkg::FIELD_W-1:0]         o_field
);

    logic [mbfr_pkg::ACC_W-1:0]   r_acc;
    logic [mbfr_pkg::ACC_W-1:0]   w_aligned;
    logic [mbfr_pkg::BYTE_W-1:0]  w_digit;

    assign w_digit = i_ctl.zero ? '0 : i_din;

    // Bytes enter at the bottom; after a full run the first byte sits on top.
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.shift) begin
            r_acc <= {r_acc[mbfr_pkg::ACC_W-mbfr_pkg::BYTE_W-1:0], w_digit};
        end
    end

    assign w_aligned = r_acc << i_sh;
    assign o_field   = w_aligned[mbfr_pkg::ACC_W-1 -: mbfr_pkg::FIELD_W]
                       & mbfr_pkg::keep_mask(i_len);

endmodule

// File: hw/rtl/msb_first_bit_field_reader_unit.sv
// MSB-first bit-field reader.
// The slave channel takes two kinds of item, chosen by i_s_tuser[0]. A load
// item appends i_s_tdata[7:0] to the payload; with i_s_tuser[1] set it first
// empties the payload and clears the read offset. A load gives no result.
// Bytes beyond the payload capacity are dropped.
// A read item takes the next i_s_tdata[14:8] bits and returns one result on
// the master channel: o_m_tuser is 1 on success and o_m_tdata holds the bits
// left-aligned with the low bits zero. A refused read returns zeros and keeps
// the offset.
// A valid read fetches the bytes one per cycle from the payload memory and
// shifts them a byte at a time into a shift register for a fixed run of nine
// shifts. A refused read skips the fetch and goes to the done state instead.
// The block takes one item at a time; a new item is accepted as soon as the
// previous result sits in the output register, even if the receiver has not
// taken it yet. When the receiver stalls, the result is held and a finished
// read waits for the output register. Reset empties the payload and clears
// the offset; the memory itself is not cleared.
module msb_first_bit_field_reader_unit #(
    parameter int MAX_PAYLOAD_BYTES = mbfr_pkg::DEF_MAX_PAYLOAD_BYTES,
    parameter int MAX_FIELD_BITS    = mbfr_pkg::DEF_MAX_FIELD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // byte_in [7:0], field_len [14:8], zero [15]
    input  logic [mbfr_pkg::S_DATA_W-1:0]     i_s_tdata,
    // func [0], first_byte [1]
    input  logic [1:0]                        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // field_bits [63:0]
    output logic [mbfr_pkg::FIELD_W-1:0]      o_m_tdata,
    // ok [0]
    output logic                              o_m_tuser
);

    localparam int ADDR_W = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
    localparam int CNT_W  = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int OFF_W  = $clog2(8 * MAX_PAYLOAD_BYTES + 1);
    localparam int SUM_W  = ((OFF_W > mbfr_pkg::LEN_W) ? OFF_W : mbfr_pkg::LEN_W) + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DONE
    } t_state;

    t_state                          r_state;
    logic [CNT_W-1:0]                r_count;
    logic [OFF_W-1:0]                r_offset;
    logic [ADDR_W-1:0]               r_addr;
    logic [mbfr_pkg::COL_W-1:0]      r_issue;
    logic                            r_rd_v;
    logic [mbfr_pkg::COL_W-1:0]      r_col;
    logic [mbfr_pkg::SH_W-1:0]       r_sh;
    logic [mbfr_pkg::LEN_W-1:0]      r_len;
    logic                            r_pass;
    logic                            r_out_valid;
    logic                            r_out_ok;
    logic [mbfr_pkg::FIELD_W-1:0]    r_out_data;

    logic                            w_acc;
    logic                            w_func;
    logic                            w_first;
    logic [mbfr_pkg::BYTE_W-1:0]     w_byte;
    logic [mbfr_pkg::LEN_W-1:0]      w_len;
    logic [SUM_W-1:0]                w_end;
    logic [SUM_W-1:0]                w_total;
    logic                            w_fail;
    logic [7:0]                      w_span;
    logic [mbfr_pkg::COL_W-1:0]      w_nbytes;
    logic                            w_has_room;
    logic                            w_we;
    logic [ADDR_W-1:0]               w_waddr;
    logic                            w_re;
    logic [mbfr_pkg::BYTE_W-1:0]     w_rdata;
    logic                            w_out_free;
    logic                            w_out_load;
    mbfr_pkg::t_shift_ctl            w_ctl;
    logic [mbfr_pkg::FIELD_W-1:0]    w_field;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_func     = i_s_tuser[0];
    assign w_first    = i_s_tuser[1];
    assign w_byte     = i_s_tdata[mbfr_pkg::BYTE_W-1:0];
    assign w_len      = i_s_tdata[mbfr_pkg::BYTE_W +: mbfr_pkg::LEN_W];

    assign w_end    = SUM_W'(r_offset) + SUM_W'(w_len);
    assign w_total  = SUM_W'({r_count, 3'b000});
    assign w_fail   = (w_len > mbfr_pkg::LEN_W'(MAX_FIELD_BITS)) || (w_end > w_total);
    assign w_span   = 8'(r_offset[2:0]) + 8'(w_len) + 8'd7;
    assign w_nbytes = w_span[3 +: mbfr_pkg::COL_W];

    assign w_has_room = r_count < CNT_W'(MAX_PAYLOAD_BYTES);
    assign w_we       = w_acc && (w_func == mbfr_pkg::FUNC_LOAD) && (w_first || w_has_room);
    assign w_waddr    = w_first ? '0 : r_count[ADDR_W-1:0];
    assign w_re       = (r_state == ST_FETCH) && (r_issue != '0);

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_out_load = (r_state == ST_DONE) && w_out_free;

    always_comb begin
        w_ctl.clear = w_acc && (w_func == mbfr_pkg::FUNC_READ);
        w_ctl.shift = (r_state == ST_FETCH) && (r_rd_v || (r_issue == '0));
        w_ctl.zero  = !r_rd_v;
    end

    mbfr_ram #(
        .WIDTH (mbfr_pkg::BYTE_W),
        .DEPTH (MAX_PAYLOAD_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_byte),
        .i_re    (w_re),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    mbfr_shifter u_shifter (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_din   (w_rdata),
        .i_sh    (r_sh),
        .i_len   (r_len),
        .o_field (w_field)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_offset    <= '0;
            r_issue     <= '0;
            r_rd_v      <= 1'b0;
            r_col       <= '0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_m_tready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            r_rd_v <= w_re;
            case (r_state)
                ST_IDLE: begin
                    if (w_acc && (w_func == mbfr_pkg::FUNC_LOAD)) begin
                        if (w_first) begin
                            r_count  <= CNT_W'(1);
                            r_offset <= '0;
                        end else if (w_has_room) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end else if (w_acc) begin
                        r_pass <= !w_fail;
                        r_sh   <= r_offset[2:0];
                        r_len  <= w_len;
                        r_addr <= r_offset[ADDR_W+2:3];
                        r_col  <= '0;
                        if (w_fail) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_issue  <= w_nbytes;
                            r_offset <= OFF_W'(w_end);
                            r_state  <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH: begin
                    if (w_re) begin
                        r_addr  <= r_addr + ADDR_W'(1);
                        r_issue <= r_issue - mbfr_pkg::COL_W'(1);
                    end
                    if (w_ctl.shift) begin
                        r_col <= r_col + mbfr_pkg::COL_W'(1);
                        if (r_col == mbfr_pkg::COL_W'(mbfr_pkg::ACC_BYTES - 1)) begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_ok    <= r_pass;
                        r_out_data  <= r_pass ? w_field : '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_ok;

    a_offset_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_W'(r_offset) <= SUM_W'({r_count, 3'b000}))
        else $error("read offset beyond loaded bits");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PAYLOAD_BYTES))
        else $error("payload count beyond capacity");

    a_refused_keeps_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_func == mbfr_pkg::FUNC_READ) && w_fail) |=> $stable(r_offset))
        else $error("refused read moved the offset");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_func == mbfr_pkg::FUNC_LOAD) && w_first)
        |=> (r_count == CNT_W'(1)) && (r_offset == '0))
        else $error("restart did not reset the payload");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> (r_out_data == '0))
        else $error("refused read returned data");

endmodule

// File: bench/msb_first_bit_field_reader_checker.sv
`timescale 1ns / 1ps

module msb_first_bit_field_reader_checker
    import mbfr_pkg::*;
#(
    parameter int MAX_BYTES = DEF_MAX_PAYLOAD_BYTES,
    parameter int MAX_FIELD = DEF_MAX_FIELD_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    // byte_in [7:0], field_len [14:8], zero [15]
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // func [0], first_byte [1]
    input  logic [1:0]          i_s_tuser,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    // field_bits [63:0]
    input  logic [FIELD_W-1:0]  i_m_tdata,
    // ok [0]
    input  logic                i_m_tuser,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_n_ok,
    output int                  o_n_refused,
    output int                  o_n_loads,
    output int                  o_n_dropped
);

    typedef struct packed {
        logic               ok;
        logic [FIELD_W-1:0] bits;
    } t_field_result;

    logic [BYTE_W-1:0] payload_bytes [MAX_BYTES];
    int                bytes_loaded;
    int                read_pos;
    t_field_result     expected_fields [$];
    int                fails;
    int                results_seen;
    int                n_ok;
    int                n_refused;
    int                n_loads;
    int                n_dropped;

    function automatic void append_byte(input logic [BYTE_W-1:0] value, input logic restart);
        if (restart) begin
            bytes_loaded = 0;
            read_pos     = 0;
        end
        if (bytes_loaded < MAX_BYTES) begin
            payload_bytes[bytes_loaded] = value;
            bytes_loaded++;
        end else begin
            n_dropped++;
        end
    endfunction

    function automatic t_field_result take_field(input int len);
        t_field_result r;
        int            pos;
        r.ok   = 1'b0;
        r.bits = '0;
        if (len > MAX_FIELD || len > FIELD_W) begin
            return r;
        end
        if (read_pos + len > bytes_loaded * BYTE_W) begin
            return r;
        end
        for (int i = 0; i < len; i++) begin
            pos = read_pos + i;
            r.bits[FIELD_W-1-i] = payload_bytes[pos / BYTE_W][BYTE_W-1 - (pos % BYTE_W)];
        end
        read_pos += len;
        r.ok = 1'b1;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_field_result want;
        if (!i_rst_n) begin
            bytes_loaded = 0;
            read_pos     = 0;
            expected_fields.delete();
            fails        = 0;
            results_seen = 0;
            n_ok         = 0;
            n_refused    = 0;
            n_loads      = 0;
            n_dropped    = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                results_seen++;
                if (expected_fields.size() == 0) begin
                    if (fails < 10) begin
                        $display("result %0d arrived with nothing expected: ok=%0b bits=%h",
                                 results_seen, i_m_tuser, i_m_tdata);
                    end
                    fails++;
                end else begin
                    want = expected_fields.pop_front();
                    if (want.ok !== i_m_tuser || want.bits !== i_m_tdata) begin
                        if (fails < 10) begin
                            $display("result %0d: expected ok=%0b bits=%h, got ok=%0b bits=%h",
                                     results_seen, want.ok, want.bits, i_m_tuser, i_m_tdata);
                        end
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == FUNC_LOAD) begin
                    n_loads++;
                    append_byte(i_s_tdata[BYTE_W-1:0], i_s_tuser[1]);
                end else begin
                    want = take_field(int'(i_s_tdata[BYTE_W+LEN_W-1:BYTE_W]));
                    if (want.ok) begin
                        n_ok++;
                    end else begin
                        n_refused++;
                    end
                    expected_fields.insert(expected_fields.size(), want);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_fields.size();
        o_n_ok       <= n_ok;
        o_n_refused  <= n_refused;
        o_n_loads    <= n_loads;
        o_n_dropped  <= n_dropped;
    end

endmodule

// File: bench/tb_msb_first_bit_field_reader_unit.sv
`timescale 1ns / 1ps

module tb_msb_first_bit_field_reader_unit;
    import mbfr_pkg::*;

    localparam int MAX_BYTES    = DEF_MAX_PAYLOAD_BYTES;
    localparam int TOTAL_ITEMS  = 1500;
    localparam int QUIET_FROM   = 1300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 30;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata;
    logic [1:0]          i_s_tuser;
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [FIELD_W-1:0]  o_m_tdata;
    logic                o_m_tuser;

    int   fail_count;
    int   pending;
    int   n_ok;
    int   n_refused;
    int   n_loads;
    int   n_dropped;
    int   items_sent;
    int   gap_odds;
    int   idle_cycles;
    logic quiet;

    msb_first_bit_field_reader_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    msb_first_bit_field_reader_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_n_ok       (n_ok),
        .o_n_refused  (n_refused),
        .o_n_loads    (n_loads),
        .o_n_dropped  (n_dropped)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("FAIL msb_first_bit_field_reader_unit");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_m_tready = 1'b0;
        forever begin
            i_m_tready = 1'b1;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12))
                @(negedge i_clk);
            if (!quiet) begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end
        end
    end

    task automatic send_item(input logic func, input logic [BYTE_W-1:0] value,
                             input logic restart, input logic [LEN_W-1:0] len);
        if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_s_tdata                        = '0;
        i_s_tdata[BYTE_W-1:0]            = value;
        i_s_tdata[BYTE_W+LEN_W-1:BYTE_W] = len;
        i_s_tuser                        = {restart, func};
        i_s_tvalid                       = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        items_sent++;
        if (items_sent >= QUIET_FROM) begin
            quiet = 1'b1;
        end
    endtask

    task automatic load_byte(input logic [BYTE_W-1:0] value, input logic restart);
        send_item(FUNC_LOAD, value, restart, LEN_W'($urandom));
    endtask

    task automatic read_field(input int len);
        send_item(FUNC_READ, BYTE_W'($urandom), 1'($urandom), LEN_W'(len));
    endtask

    task automatic hold_until_drained();
        i_s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int filled;
        int pos;
        int room;
        int len;
        int frame_bytes;
        int choice;
        logic do_read;

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        items_sent  = 0;
        gap_odds    = 0;
        idle_cycles = 0;
        quiet       = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        gap_odds = 3;
        read_field(0);
        read_field(1);
        load_byte(8'hA5, 1'b1);
        read_field(8);
        read_field(1);
        load_byte(8'hFF, 1'b0);
        load_byte(8'h00, 1'b0);
        load_byte(8'h80, 1'b0);
        load_byte(8'h01, 1'b0);
        load_byte(8'h7F, 1'b0);
        load_byte(8'hFE, 1'b0);
        load_byte(8'h55, 1'b0);
        load_byte(8'hAA, 1'b0);
        read_field(3);
        read_field(64);
        load_byte(8'hC3, 1'b0);
        read_field(64);
        read_field(127);
        read_field(65);
        read_field(5);
        read_field(0);
        load_byte(8'h3C, 1'b1);
        read_field(8);
        hold_until_drained();
        filled = 1;
        pos    = 8;

        while (items_sent < TOTAL_ITEMS) begin
            gap_odds    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
            frame_bytes = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70)
                                                      : $urandom_range(1, 12);
            // Now and then a frame continues the previous payload instead of restarting it.
            if ($urandom_range(0, 9) != 0) begin
                load_byte(BYTE_W'($urandom), 1'b1);
                filled = 1;
                pos    = 0;
                frame_bytes--;
            end
            repeat (frame_bytes) begin
                load_byte(BYTE_W'($urandom), 1'b0);
                if (filled < MAX_BYTES) begin
                    filled++;
                end
            end
            repeat ($urandom_range(1, 8)) begin
                room    = filled * BYTE_W - pos;
                choice  = $urandom_range(0, 19);
                do_read = 1'b1;
                if (choice == 0) begin
                    len = 0;
                end else if (choice == 1) begin
                    len = $urandom_range(65, 127);
                end else if (choice == 2) begin
                    len = room + $urandom_range(1, 8);
                    if (len > 127) begin
                        len = 127;
                    end
                end else if (choice == 3) begin
                    len = FIELD_W;
                end else if (choice == 4) begin
                    do_read = 1'b0;
                    load_byte(BYTE_W'($urandom), 1'b0);
                    if (filled < MAX_BYTES) begin
                        filled++;
                    end
                end else if (room == 0) begin
                    len = $urandom_range(0, FIELD_W);
                end else begin
                    len = $urandom_range(1, (room < FIELD_W) ? room : FIELD_W);
                end
                if (do_read) begin
                    read_field(len);
                    if (len <= FIELD_W && len <= room) begin
                        pos += len;
                    end
                end
            end
            if ($urandom_range(0, 7) == 0) begin
                hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d items: %0d byte loads (%0d dropped at a full payload), %0d fields read, %0d reads refused.",
                 items_sent, n_loads, n_dropped, n_ok, n_refused);
        $display("Fields ranged from zero-length to over-long and past the end, with random stalls on both sides.");
        if (fail_count == 0 && pending == 0) begin
            $display("PASS msb_first_bit_field_reader_unit");
        end else begin
            $display("FAIL msb_first_bit_field_reader_unit");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/mbfr_pkg.sv
hw/rtl/mbfr_ram.sv
hw/rtl/mbfr_shifter.sv
hw/rtl/msb_first_bit_field_reader_unit.sv
bench/msb_first_bit_field_reader_checker.sv
bench/tb_msb_first_bit_field_reader_unit.sv
